// ===== hw/rtl/epw_pkg.sv =====
// Shared types, constants and table helpers for the partial-update waveform block.
// No dependencies.
package epw_pkg;

  localparam int PIX_BITS     = 8;
  localparam int NIB_BITS     = 4;
  localparam int TBL_BITS     = 64;
  localparam int ONES_BITS    = 4;
  localparam int TOTAL_BITS   = 20;
  localparam int CFG_IDX_BITS = 2;
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 40;

  localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE_LOW  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WHITE_HIGH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK_LOW  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLACK_HIGH = 2'd3;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef logic [TBL_BITS-1:0] tbl_t;

  typedef struct packed {
    logic frame_start;
    pix_t drawn;
    pix_t shown;
  } epw_item_t;

  typedef struct packed {
    tbl_t white_lo;
    tbl_t white_hi;
    tbl_t black_lo;
    tbl_t black_hi;
  } epw_tables_t;

  function automatic pix_t table_entry(input tbl_t lo, input tbl_t hi,
                                       input logic [NIB_BITS-1:0] nib);
    tbl_t word;
    word = nib[NIB_BITS-1] ? hi : lo;
    return word[nib[NIB_BITS-2:0]*PIX_BITS +: PIX_BITS];
  endfunction

endpackage

// ===== hw/rtl/epw_lookup.sv =====
// Mask forming and table lookup: gives both drive bytes for one item.
// Depends on epw_pkg.
module epw_lookup (
  input  epw_pkg::epw_item_t   item,
  input  epw_pkg::epw_tables_t tables,
  output epw_pkg::pix_t        drive_high,
  output epw_pkg::pix_t        drive_low,
  output logic [epw_pkg::ONES_BITS-1:0] whiten_ones
);
  import epw_pkg::*;

  pix_t whiten;
  pix_t blacken;

  assign whiten  = item.shown & ~item.drawn;
  assign blacken = ~item.shown & item.drawn;

  assign drive_high =
    table_entry(tables.white_lo, tables.white_hi, whiten[7:4]) &
    table_entry(tables.black_lo, tables.black_hi, blacken[7:4]);
  assign drive_low =
    table_entry(tables.white_lo, tables.white_hi, whiten[3:0]) &
    table_entry(tables.black_lo, tables.black_hi, blacken[3:0]);

  always_comb begin
    whiten_ones = '0;
    for (int b = 0; b < PIX_BITS; b++) begin
      whiten_ones = whiten_ones + ONES_BITS'(whiten[b]);
    end
  end

endmodule

// ===== hw/rtl/epw_count.sv =====
// Saturating per-frame count of whitening pixels.
// Depends on epw_pkg.
module epw_count #(
  parameter int COUNT_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           clear,
  input  logic [epw_pkg::ONES_BITS-1:0]  ones,
  output logic [COUNT_BITS-1:0]          count_nxt
);
  import epw_pkg::*;

  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] base;
  logic [COUNT_BITS:0]   sum;

  assign base = clear ? '0 : count_r;
  assign sum  = {1'b0, base} + (COUNT_BITS+1)'(ones);
  assign count_nxt = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (en) begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/epaper_partial_update_waveform.sv =====
// Partial-update waveform former: input register, table lookup and count, result register.
// An accepted item reaches out_tvalid through two register stages: input, then result.
// Throughput: one item per cycle unless out_tready stalls; single lookup and count pass.
// Reset (rst_n low, synchronous): clears the count, all four tables and both valid flags.
// Depends on epw_pkg, epw_lookup, epw_count.
module epaper_partial_update_waveform #(
  parameter int COUNT_BITS = 20
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [epw_pkg::IN_DATA_BITS-1:0]     in_tdata,  // shown_byte, drawn_byte
  input  logic                                 in_tuser,  // frame_start
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [epw_pkg::OUT_DATA_BITS-1:0]    out_tdata, // drive_high, drive_low,
                                                          // whitening_total, zero pad
  input  logic                                 cfg_we,
  input  logic [epw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [epw_pkg::TBL_BITS-1:0]         cfg_wdata
);
  import epw_pkg::*;

  epw_tables_t tables_r;
  epw_item_t   item_r;
  logic        item_vld_r;
  logic        out_vld_r;
  pix_t        drive_high_r;
  pix_t        drive_low_r;
  logic [TOTAL_BITS-1:0] total_r;

  pix_t                  drive_high;
  pix_t                  drive_low;
  logic [ONES_BITS-1:0]  whiten_ones;
  logic [COUNT_BITS-1:0] count_nxt;
  logic [31:0]           count_ext;
  logic                  adv;

  assign adv       = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tables_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHITE_LOW:  tables_r.white_lo <= cfg_wdata;
        CFG_WHITE_HIGH: tables_r.white_hi <= cfg_wdata;
        CFG_BLACK_LOW:  tables_r.black_lo <= cfg_wdata;
        CFG_BLACK_HIGH: tables_r.black_hi <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= '{frame_start: in_tuser, drawn: in_tdata[15:8], shown: in_tdata[7:0]};
    end
  end

  epw_lookup u_lookup (
    .item        (item_r),
    .tables      (tables_r),
    .drive_high  (drive_high),
    .drive_low   (drive_low),
    .whiten_ones (whiten_ones)
  );

  epw_count #(
    .COUNT_BITS (COUNT_BITS)
  ) u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .clear     (item_r.frame_start),
    .ones      (whiten_ones),
    .count_nxt (count_nxt)
  );

  assign count_ext = 32'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= item_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_high_r <= drive_high;
      drive_low_r  <= drive_low;
      total_r      <= count_ext[TOTAL_BITS-1:0];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_BITS-TOTAL_BITS-2*PIX_BITS){1'b0}},
                       total_r, drive_low_r, drive_high_r};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for epaper_partial_update_waveform: streams pixel byte pairs, predicts the drive
// bytes and whitening total per item, and checks every result in order.
// Depends on epw_pkg and the block's RTL.
module testbench;
  import epw_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam logic [19:0] TOTAL_MAX   = 20'hFFFFF;

  typedef struct packed {
    pix_t        hi_byte;
    pix_t        lo_byte;
    logic [19:0] total;
  } drive_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;   // shown_byte, drawn_byte
  logic                     in_tuser;   // frame_start
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;  // drive_high, drive_low, whitening_total, zero pad
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [TBL_BITS-1:0]      cfg_wdata;

  drive_t      drive_q[$];
  tbl_t        white_lo, white_hi, black_lo, black_hi;
  logic [19:0] whiten_total;
  int          mismatches;
  bit          send_gaps;
  bit          recv_gaps;
  int          hold_len;
  int          idle_cycles;

  epaper_partial_update_waveform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic pix_t table_byte(tbl_t lo, tbl_t hi, logic [3:0] nib);
    tbl_t word;
    word = nib[3] ? hi : lo;
    return pix_t'(word >> (8 * nib[2:0]));
  endfunction

  function automatic drive_t predict_drive(pix_t shown, pix_t drawn, logic start);
    pix_t   whiten, blacken;
    int     sum;
    drive_t d;
    whiten  = shown & ~drawn;
    blacken = ~shown & drawn;
    if (start) whiten_total = '0;
    sum = int'(whiten_total) + $countones(whiten);
    whiten_total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : 20'(sum);
    d.hi_byte = table_byte(white_lo, white_hi, whiten[7:4]) &
                table_byte(black_lo, black_hi, blacken[7:4]);
    d.lo_byte = table_byte(white_lo, white_hi, whiten[3:0]) &
                table_byte(black_lo, black_hi, blacken[3:0]);
    d.total   = whiten_total;
    return d;
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
  endfunction

  task automatic send_pixels(pix_t shown, pix_t drawn, logic start);
    int gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {drawn, shown};
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    drive_q.push_back(predict_drive(shown, drawn, start));
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_table(logic [CFG_IDX_BITS-1:0] idx, tbl_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WHITE_LOW:  white_lo = val;
      CFG_WHITE_HIGH: white_hi = val;
      CFG_BLACK_LOW:  black_lo = val;
      CFG_BLACK_HIGH: black_hi = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_tables(tbl_t wl, tbl_t wh, tbl_t bl, tbl_t bh);
    write_table(CFG_WHITE_LOW, wl);
    write_table(CFG_WHITE_HIGH, wh);
    write_table(CFG_BLACK_LOW, bl);
    write_table(CFG_BLACK_HIGH, bh);
  endtask

  function automatic tbl_t rand_table();
    return {$urandom, $urandom};
  endfunction

  // Result side: random stalls per item, plus one long hold-off on request
  initial begin
    int     stall;
    drive_t want;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = recv_gaps ? $urandom_range(0, 4) : 0;
      @(negedge clk);
      if (hold_len > 0) begin
        stall    = hold_len;
        hold_len = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (drive_q.size() == 0) begin
        note_mismatch("unexpected result", 32'h0, 32'(out_tdata));
      end else begin
        want = drive_q.pop_front();
        if (out_tdata[7:0] != want.hi_byte)
          note_mismatch("drive_high", 32'(want.hi_byte), 32'(out_tdata[7:0]));
        if (out_tdata[15:8] != want.lo_byte)
          note_mismatch("drive_low", 32'(want.lo_byte), 32'(out_tdata[15:8]));
        if (out_tdata[35:16] != want.total)
          note_mismatch("whitening_total", 32'(want.total), 32'(out_tdata[35:16]));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic test_reset_tables();
    send_pixels(8'hFF, 8'h00, 1'b1);
    send_pixels(8'h00, 8'hFF, 1'b0);
    send_pixels(8'hA5, 8'h3C, 1'b0);
    settle();
  endtask

  task automatic test_lookup_extremes();
    logic [15:0] pairs[10];
    pairs = '{16'h0000, 16'hFFFF, 16'hFF00, 16'h00FF, 16'hF00F,
              16'h0FF0, 16'hAA55, 16'h55AA, 16'hC369, 16'h817E};
    // distinct entries on one side, all ones on the other, so each lookup shows through
    load_tables('1, '1, 64'h7766554433221100, 64'hFFEEDDCCBBAA9988);
    foreach (pairs[i]) send_pixels(pairs[i][15:8], pairs[i][7:0], i == 0 || i == 5);
    settle();
    load_tables(64'h7766554433221100, 64'hFFEEDDCCBBAA9988, '1, '1);
    foreach (pairs[i]) send_pixels(pairs[i][15:8], pairs[i][7:0], i == 0 || i == 7);
    settle();
  endtask

  task automatic test_frame_restart();
    load_tables(rand_table(), rand_table(), rand_table(), rand_table());
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    send_pixels(8'hFF, 8'h00, 1'b1);
    // eight whitening pixels per item, then a restart mid-stream
    repeat (10) send_pixels(8'hFF, 8'h00, 1'b0);
    repeat (10) send_pixels(8'($urandom), 8'($urandom), 1'b0);
    send_pixels(8'h0F, 8'h00, 1'b1);
    send_pixels(8'hFF, 8'h00, 1'b0);
    settle();
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_len  = 80;
    repeat (30) send_pixels(8'($urandom), 8'($urandom), 1'($urandom_range(0, 7) == 0));
    settle();
    send_gaps = 1'b1;
  endtask

  task automatic test_random();
    pix_t shown, drawn;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       load_tables('0, '0, '0, '0);
        1:       load_tables('1, '1, '1, '1);
        default: load_tables(rand_table(), rand_table(), rand_table(), rand_table());
      endcase
      send_gaps = (ph != 3);
      recv_gaps = (ph != 3);
      repeat (250) begin
        shown = 8'($urandom);
        case ($urandom_range(0, 3))
          0:       drawn = ~shown;
          1:       drawn = shown;
          default: drawn = 8'($urandom);
        endcase
        send_pixels(shown, drawn, 1'($urandom_range(0, 31) == 0));
      end
      settle();
    end
    send_gaps = 1'b1;
    recv_gaps = 1'b1;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_WHITE_LOW;
    cfg_wdata    = '0;
    white_lo     = '0;
    white_hi     = '0;
    black_lo     = '0;
    black_hi     = '0;
    whiten_total = '0;
    mismatches   = 0;
    send_gaps    = 1'b1;
    recv_gaps    = 1'b1;
    hold_len     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_tables();
    test_lookup_extremes();
    test_backpressure();
    test_random();
    test_frame_restart();

    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/epw_pkg.sv
hw/rtl/epw_lookup.sv
hw/rtl/epw_count.sv
hw/rtl/epaper_partial_update_waveform.sv
tb/sv/testbench.sv
